// File: sv/aws_pkg.sv
package aws_pkg;

    localparam int unsigned WORD_W = 32;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              set_end;
    } t_in_item;

endpackage

// File: sv/ascending_word_sorter.sv
// Words load at one per cycle while the core is loading a set. A set of N
// words is sorted by bubble passes over L words for L = N down to 2, and its
// first word is then read from the RAM and presented. Words leave at one per
// cycle while the receiver is ready; the next set is taken only after the last
// word of the set is accepted, with two items held in the queue.
// Reset is synchronous and active low and empties the queue and the set.
module ascending_word_sorter #(
    parameter int unsigned SET_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // word_in
    input  logic        s_axis_tlast,  // set_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // word_out
    output logic        m_axis_tlast,  // final_word
    output logic        m_axis_tuser   // overflowed
);

    aws_pkg::t_in_item w_in;
    aws_pkg::t_in_item w_q;
    logic              w_qv;
    logic              w_qr;

    assign w_in.word    = s_axis_tdata;
    assign w_in.set_end = s_axis_tlast;

    aws_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_item (w_in),
        .o_valid(w_qv),
        .i_ready(w_qr),
        .o_item (w_q)
    );

    aws_core #(.SET_DEPTH(SET_DEPTH)) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_qv),
        .o_ready(w_qr),
        .i_item (w_q),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_word (m_axis_tdata),
        .o_final(m_axis_tlast),
        .o_ovf  (m_axis_tuser)
    );

endmodule

// File: sv/aws_ram.sv
module aws_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/aws_fifo.sv
module aws_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  aws_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output aws_pkg::t_in_item o_item
);

    aws_pkg::t_in_item r_slot [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: sv/aws_core.sv
module aws_core #(
    parameter int unsigned SET_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  aws_pkg::t_in_item          i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [aws_pkg::WORD_W-1:0] o_word,
    output logic                       o_final,
    output logic                       o_ovf
);

    localparam int unsigned AW = $clog2(SET_DEPTH);
    localparam int unsigned CW = $clog2(SET_DEPTH + 2);
    localparam int unsigned W  = aws_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_SORT = 4'b0010,
        S_RD   = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_cnt;
    logic             r_drop;
    logic [CW-1:0]    r_len;
    logic [CW-1:0]    r_k;
    logic [CW-1:0]    r_idx;
    logic [W-1:0]     r_carry;
    logic             r_ovf;
    logic             r_fin;
    logic             r_ov;
    logic             w_acc;
    logic             w_store;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    logic [W-1:0]     w_wdata;
    logic [W-1:0]     w_rdata;
    logic [W-1:0]     w_min;
    logic [W-1:0]     w_max;
    logic [CW-1:0]    w_k2;
    logic [CW-1:0]    w_idx1;

    assign o_ready = (r_state == S_LOAD);
    assign w_acc   = i_valid && o_ready;
    assign w_store = w_acc && (r_cnt < CW'(SET_DEPTH));
    assign o_valid = r_ov;
    assign o_word  = w_rdata;
    assign w_k2    = r_k - CW'(2);
    assign w_idx1  = r_idx + CW'(1);
    assign w_min   = (r_carry > w_rdata) ? w_rdata : r_carry;
    assign w_max   = (r_carry > w_rdata) ? r_carry : w_rdata;

    // A bubble pass over L words keeps the larger word in a carry register and
    // writes the smaller one back one place lower; the carry lands at L-1.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = i_item.word;
        w_raddr = r_idx[AW-1:0];
        case (r_state)
            S_LOAD: begin
                w_we = w_store;
            end
            S_SORT: begin
                w_raddr = r_k[AW-1:0];
                w_waddr = w_k2[AW-1:0];
                w_wdata = (r_k == r_len + CW'(1)) ? r_carry : w_min;
                w_we    = (r_len >= CW'(2)) && (r_k >= CW'(2));
            end
            S_RD: begin
                w_raddr = r_idx[AW-1:0];
            end
            S_EMIT: begin
                if (i_ready) begin
                    w_raddr = w_idx1[AW-1:0];
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    aws_ram #(.WIDTH(W), .DEPTH(SET_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_len   <= '0;
            r_k     <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
            r_ovf   <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (w_store) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_item.set_end) begin
                            r_state <= S_SORT;
                            r_k     <= '0;
                            r_len   <= w_store ? (r_cnt + CW'(1)) : r_cnt;
                            r_ovf   <= r_drop || !w_store;
                        end
                    end
                end
                S_SORT: begin
                    if (r_len < CW'(2)) begin
                        r_state <= S_RD;
                        r_idx   <= '0;
                        r_fin   <= (r_cnt == CW'(1));
                    end else if (r_k == r_len + CW'(1)) begin
                        r_k   <= '0;
                        r_len <= r_len - CW'(1);
                    end else begin
                        r_k <= r_k + CW'(1);
                        if (r_k == CW'(1)) begin
                            r_carry <= w_rdata;
                        end else if (r_k >= CW'(2)) begin
                            r_carry <= w_max;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EMIT;
                    r_ov    <= 1'b1;
                end
                S_EMIT: begin
                    if (i_ready) begin
                        if (r_fin) begin
                            r_ov    <= 1'b0;
                            r_state <= S_LOAD;
                            r_cnt   <= '0;
                            r_drop  <= 1'b0;
                        end else begin
                            r_idx <= w_idx1;
                            r_fin <= ((r_idx + CW'(2)) == r_cnt);
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_final = r_fin;
    assign o_ovf   = r_ovf;

endmodule

// File: tb/sv/tb_ascending_word_sorter.sv
`timescale 1ns / 100ps

module tb_ascending_word_sorter;

    localparam int unsigned WORD_W = aws_pkg::WORD_W;
    localparam int unsigned DEPTH = 16;
    localparam int unsigned NUM_RANDOM = 220;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              final_word;
        logic              overflowed;
    } t_sorted_word;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              set_end;
        logic              has_exp;
        logic [WORD_W-1:0] exp_word;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;   // word_in
    logic              s_axis_tlast;   // set_end
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;   // word_out
    logic              m_axis_tlast;   // final_word
    logic              m_axis_tuser;   // overflowed

    ascending_word_sorter #(.SET_DEPTH(DEPTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [WORD_W-1:0] set_words[$];
    logic              set_dropped;
    t_sorted_word      sorted_queue[$];
    int unsigned       error_count;
    int unsigned       idle_cycles;
    bit                no_idle;
    t_stim_row         directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Collects a word and, when the set closes, queues its sorted words.
    task automatic collect_word(input logic [WORD_W-1:0] word, input logic set_end);
        logic [WORD_W-1:0] tmp;
        int n;
        if (set_words.size() < DEPTH) begin
            set_words.push_back(word);
        end else begin
            set_dropped = 1'b1;
        end
        if (set_end) begin
            n = set_words.size();
            for (int p = 0; p + 1 < n; p++) begin
                for (int k = 0; k + 1 < n - p; k++) begin
                    if (set_words[k] > set_words[k+1]) begin
                        tmp = set_words[k];
                        set_words[k] = set_words[k+1];
                        set_words[k+1] = tmp;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                sorted_queue.push_back('{set_words[k], k == n - 1, set_dropped});
            end
            set_words.delete();
            set_dropped = 1'b0;
        end
    endtask

    // Drives one word and waits until it is accepted.
    task automatic send_word(input logic [WORD_W-1:0] word, input logic set_end);
        while (!no_idle && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= set_end;
        do @(posedge i_clk); while (!s_axis_tready);
        collect_word(word, set_end);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        t_sorted_word got;
        t_sorted_word exp;
        bit           hit;
        if (i_rst_n) begin
            hit = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready);
            if (hit) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
                if (sorted_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected item %h", got.word));
                end else begin
                    exp = sorted_queue.pop_front();
                    if (got.word !== exp.word)
                        report_mismatch($sformatf("word %h, expected %h",
                                                  got.word, exp.word));
                    if (got.final_word !== exp.final_word)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  got.final_word, exp.final_word));
                    if (got.overflowed !== exp.overflowed)
                        report_mismatch($sformatf("overflow %b, expected %b",
                                                  got.overflowed, exp.overflowed));
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout with %0d items outstanding.", sorted_queue.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Pushes a directed row, optionally with a typed expected word.
    task automatic add_row(input logic [WORD_W-1:0] w, input logic e,
                           input logic has, input logic [WORD_W-1:0] x);
        directed_rows.push_back('{w, e, has, x});
    endtask

    task automatic send_random_set(input int len, input int mode);
        logic [WORD_W-1:0] w;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: w = $urandom();
                1: w = $urandom_range(7);
                default: w = {$urandom_range(1) ? 32'hFFFF_FFF0 : 32'h0} | $urandom_range(15);
            endcase
            send_word(w, i == len - 1);
        end
    endtask

    initial begin
        int sent;
        int len;
        int sz;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        set_dropped   = 1'b0;
        error_count   = 0;
        idle_cycles   = 0;
        no_idle       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // One-word sets, including the extremes, come back unchanged.
        add_row(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000);
        add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_row(32'h5555_5555, 1'b1, 1'b1, 32'h5555_5555);
        // Short set with extremes and ties.
        add_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        add_row(32'hAAAA_AAAA, 1'b0, 1'b0, '0);
        add_row(32'h0000_0000, 1'b0, 1'b0, '0);
        add_row(32'hAAAA_AAAA, 1'b1, 1'b0, '0);
        // Full set in descending order, then an overflowing set closed by a dropped word.
        for (int i = 0; i < DEPTH; i++) add_row(32'hFFFF_FFFF - i, i == DEPTH - 1, 1'b0, '0);
        for (int i = 0; i < DEPTH + 2; i++) add_row(DEPTH + 2 - i, i == DEPTH + 1, 1'b0, '0);
        for (int i = 0; i < directed_rows.size(); i++) begin
            send_word(directed_rows[i].word, directed_rows[i].set_end);
            if (directed_rows[i].has_exp) begin
                void'(sorted_queue.pop_back());
                sorted_queue.push_back('{directed_rows[i].exp_word, 1'b1, 1'b0});
            end
        end

        sent = 0;
        while (sent < NUM_RANDOM) begin
            no_idle = (sent > 100 && sent < 150);
            sz = $urandom_range(99);
            if (sz < 10) len = 1;
            else if (sz < 80) len = $urandom_range(2, 8);
            else if (sz < 92) len = DEPTH;
            else len = $urandom_range(DEPTH + 1, DEPTH + 4);
            send_random_set(len, $urandom_range(2));
            sent += len;
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (sorted_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && set_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
